### src/qpr_pkg.sv
package qpr_pkg;

    // Width of every component field on the ports.
    localparam int FIELD_W = 32;

    // Command codes.
    localparam logic CMD_PRODUCT = 1'b0;
    localparam logic CMD_ROTATE  = 1'b1;

    // One request item: command, operand A and quaternion B.
    typedef struct packed {
        logic                      command;
        logic signed [FIELD_W-1:0] a_x;
        logic signed [FIELD_W-1:0] a_y;
        logic signed [FIELD_W-1:0] a_z;
        logic signed [FIELD_W-1:0] a_w;
        logic signed [FIELD_W-1:0] b_x;
        logic signed [FIELD_W-1:0] b_y;
        logic signed [FIELD_W-1:0] b_z;
        logic signed [FIELD_W-1:0] b_w;
    } req_t;

    // One response item: result quaternion and the clip flag.
    typedef struct packed {
        logic signed [FIELD_W-1:0] r_x;
        logic signed [FIELD_W-1:0] r_y;
        logic signed [FIELD_W-1:0] r_z;
        logic signed [FIELD_W-1:0] r_w;
        logic                      saturated;
    } rsp_t;

endpackage

### src/quaternion_product_and_rotate_core.sv
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   qpr_pkg::req_t (command, A, B)
// rsp       out        rsp_valid/rsp_stall   qpr_pkg::rsp_t (R, saturated)
//
// The core accepts one item per clock while req_stall is low.
// The pipeline is an input register followed by two multiply passes, each of which takes
// a product stage, a pair-add stage and a final add with shift and saturation.
// Reset clears only the stage valid bits; the data registers are not reset.
// A stalled result holds in the output register, and the stages upstream keep
// moving until they run into it, so empty stages are filled while the output waits.
module quaternion_product_and_rotate_core #(
    parameter int FRAC_BITS  = 16,
    parameter int COMP_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  qpr_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output qpr_pkg::rsp_t rsp
);
    import qpr_pkg::*;

    // Operands are one bit wider than a component so that the conjugate of B
    // never overflows. Products are exact, and the four-term sum has two guard bits.
    localparam int OPW = COMP_WIDTH + 1;
    localparam int PW  = 2 * OPW;
    localparam int SW  = PW + 2;
    localparam int NST = 7;

    typedef logic signed [COMP_WIDTH-1:0] comp_t;
    typedef logic signed [OPW-1:0]        opnd_t;
    typedef logic signed [PW-1:0]         prod_t;
    typedef logic signed [SW-1:0]         sum_t;

    localparam sum_t SAT_MAX = sum_t'({1'b0, {(COMP_WIDTH-1){1'b1}}});
    localparam sum_t SAT_MIN = ~SAT_MAX;

    localparam logic [1:0] W_IDX = 2'd3;

    // Hamilton product term selection. Each result component is the sum of
    // p[TERM_P[c][t]] * q[TERM_Q[c][t]] over four terms, with components ordered x, y, z, w.
    // Signs: for x, y and z the terms are + + + -, and for w they are + - - -.
    localparam logic [1:0] TERM_P [4][4] = '{
        '{2'd3, 2'd0, 2'd2, 2'd1},
        '{2'd3, 2'd1, 2'd0, 2'd2},
        '{2'd3, 2'd2, 2'd1, 2'd0},
        '{2'd3, 2'd0, 2'd1, 2'd2}
    };
    localparam logic [1:0] TERM_Q [4][4] = '{
        '{2'd0, 2'd3, 2'd1, 2'd2},
        '{2'd1, 2'd3, 2'd2, 2'd0},
        '{2'd2, 2'd3, 2'd0, 2'd1},
        '{2'd3, 2'd0, 2'd1, 2'd2}
    };

    // The component is taken from the low bits of the field. When the component is
    // wider than the field, the component's upper bits are zero.
    function automatic comp_t field_to_comp(input logic [FIELD_W-1:0] f);
        logic [COMP_WIDTH+FIELD_W-1:0] t;
        t = {{COMP_WIDTH{1'b0}}, f};
        return comp_t'(t[COMP_WIDTH-1:0]);
    endfunction

    // A result component is sign-extended or truncated to the field width.
    function automatic logic [FIELD_W-1:0] comp_to_field(input comp_t c);
        logic [COMP_WIDTH+FIELD_W-1:0] t;
        t = {{FIELD_W{c[COMP_WIDTH-1]}}, c};
        return t[FIELD_W-1:0];
    endfunction

    // The sum is shifted arithmetically, which rounds toward minus infinity,
    // and is then clipped to the component range.
    function automatic comp_t finish(input sum_t v, output logic clip);
        sum_t s;
        s = v >>> FRAC_BITS;
        clip = 1'b0;
        if (s > SAT_MAX)
        begin
            clip = 1'b1;
            return comp_t'(SAT_MAX[COMP_WIDTH-1:0]);
        end
        if (s < SAT_MIN)
        begin
            clip = 1'b1;
            return comp_t'(SAT_MIN[COMP_WIDTH-1:0]);
        end
        return comp_t'(s[COMP_WIDTH-1:0]);
    endfunction

    // Stage valid bits and load enables. Bit 0 is the input register.
    logic [NST-1:0] valid_reg;
    logic [NST-1:0] en;

    // Stage 1: input register.
    logic  s1_cmd_reg;
    comp_t s1_a_reg [4];
    comp_t s1_b_reg [4];

    // Stage 2: the sixteen products of the first pass.
    logic  s2_cmd_reg;
    comp_t s2_b_reg    [4];
    prod_t s2_prod_reg [4][4];
    prod_t s2_prod_next [4][4];
    opnd_t p_op [4];
    opnd_t q_op [4];

    // Stage 3: the partial sums of the first pass.
    logic  s3_cmd_reg;
    comp_t s3_b_reg    [4];
    sum_t  s3_head_reg [4];
    sum_t  s3_tail_reg [4];
    sum_t  s3_head_next [4];
    sum_t  s3_tail_next [4];

    // Stage 4: the first Hamilton result, which is the final result for a product and
    // the intermediate quaternion for a rotation.
    logic  s4_cmd_reg;
    comp_t s4_b_reg   [4];
    comp_t s4_mid_reg [4];
    logic  s4_sat_reg;
    comp_t s4_mid_next [4];
    logic  s4_sat_next;
    logic  clip1 [4];

    // Stage 5: the products of the second pass, which rotation needs only for x, y and z.
    logic  s5_cmd_reg;
    comp_t s5_mid_reg  [4];
    logic  s5_sat_reg;
    prod_t s5_prod_reg [3][4];
    prod_t s5_prod_next [3][4];

    // Stage 6: the partial sums of the second pass.
    logic  s6_cmd_reg;
    comp_t s6_mid_reg  [4];
    logic  s6_sat_reg;
    sum_t  s6_head_reg [3];
    sum_t  s6_tail_reg [3];
    sum_t  s6_head_next [3];
    sum_t  s6_tail_next [3];

    // Stage 7: the output register.
    logic  s7_cmd_reg;
    rsp_t  rsp_reg;
    rsp_t  rsp_next;
    comp_t rot [3];
    logic  clip2 [3];

    // A stage loads when it is empty or when the stage after it loads.
    always_comb
    begin
        en[NST-1] = !valid_reg[NST-1] || !rsp_stall;
        for (int k = NST - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign req_stall = !en[0];
    assign rsp_valid = valid_reg[NST-1];
    assign rsp       = rsp_reg;

    // First pass operands. A product uses A and B directly. A rotation uses
    // conj(B) times (A.xyz, 0).
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (s1_cmd_reg == CMD_ROTATE)
            begin
                if (i == 3)
                begin
                    p_op[i] = opnd_t'(s1_b_reg[i]);
                    q_op[i] = '0;
                end
                else
                begin
                    p_op[i] = -opnd_t'(s1_b_reg[i]);
                    q_op[i] = opnd_t'(s1_a_reg[i]);
                end
            end
            else
            begin
                p_op[i] = opnd_t'(s1_a_reg[i]);
                q_op[i] = opnd_t'(s1_b_reg[i]);
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int t = 0; t < 4; t++)
            begin
                s2_prod_next[c][t] = prod_t'(p_op[TERM_P[c][t]]) * prod_t'(q_op[TERM_Q[c][t]]);
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            if (2'(c) == W_IDX)
            begin
                s3_head_next[c] = sum_t'(s2_prod_reg[c][0]) - sum_t'(s2_prod_reg[c][1]);
                s3_tail_next[c] = -sum_t'(s2_prod_reg[c][2]) - sum_t'(s2_prod_reg[c][3]);
            end
            else
            begin
                s3_head_next[c] = sum_t'(s2_prod_reg[c][0]) + sum_t'(s2_prod_reg[c][1]);
                s3_tail_next[c] = sum_t'(s2_prod_reg[c][2]) - sum_t'(s2_prod_reg[c][3]);
            end
        end
    end

    always_comb
    begin
        s4_sat_next = 1'b0;
        for (int c = 0; c < 4; c++)
        begin
            s4_mid_next[c] = finish(s3_head_reg[c] + s3_tail_reg[c], clip1[c]);
            s4_sat_next    = s4_sat_next | clip1[c];
        end
    end

    // Second pass: the intermediate quaternion times B.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            for (int t = 0; t < 4; t++)
            begin
                s5_prod_next[c][t] = prod_t'(s4_mid_reg[TERM_P[c][t]])
                                   * prod_t'(s4_b_reg[TERM_Q[c][t]]);
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            s6_head_next[c] = sum_t'(s5_prod_reg[c][0]) + sum_t'(s5_prod_reg[c][1]);
            s6_tail_next[c] = sum_t'(s5_prod_reg[c][2]) - sum_t'(s5_prod_reg[c][3]);
        end
    end

    // For a product, the stage 4 result passes straight through. For a rotation,
    // x, y and z come from the second pass and w is zero. Any clip in the intermediate
    // quaternion still counts.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            rot[c] = finish(s6_head_reg[c] + s6_tail_reg[c], clip2[c]);
        end
        if (s6_cmd_reg == CMD_ROTATE)
        begin
            rsp_next.r_x       = comp_to_field(rot[0]);
            rsp_next.r_y       = comp_to_field(rot[1]);
            rsp_next.r_z       = comp_to_field(rot[2]);
            rsp_next.r_w       = '0;
            rsp_next.saturated = s6_sat_reg | clip2[0] | clip2[1] | clip2[2];
        end
        else
        begin
            rsp_next.r_x       = comp_to_field(s6_mid_reg[0]);
            rsp_next.r_y       = comp_to_field(s6_mid_reg[1]);
            rsp_next.r_z       = comp_to_field(s6_mid_reg[2]);
            rsp_next.r_w       = comp_to_field(s6_mid_reg[3]);
            rsp_next.saturated = s6_sat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= req_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_cmd_reg  <= req.command;
            s1_a_reg[0] <= field_to_comp(req.a_x);
            s1_a_reg[1] <= field_to_comp(req.a_y);
            s1_a_reg[2] <= field_to_comp(req.a_z);
            s1_a_reg[3] <= field_to_comp(req.a_w);
            s1_b_reg[0] <= field_to_comp(req.b_x);
            s1_b_reg[1] <= field_to_comp(req.b_y);
            s1_b_reg[2] <= field_to_comp(req.b_z);
            s1_b_reg[3] <= field_to_comp(req.b_w);
        end
        if (en[1])
        begin
            s2_cmd_reg  <= s1_cmd_reg;
            s2_b_reg    <= s1_b_reg;
            s2_prod_reg <= s2_prod_next;
        end
        if (en[2])
        begin
            s3_cmd_reg  <= s2_cmd_reg;
            s3_b_reg    <= s2_b_reg;
            s3_head_reg <= s3_head_next;
            s3_tail_reg <= s3_tail_next;
        end
        if (en[3])
        begin
            s4_cmd_reg <= s3_cmd_reg;
            s4_b_reg   <= s3_b_reg;
            s4_mid_reg <= s4_mid_next;
            s4_sat_reg <= s4_sat_next;
        end
        if (en[4])
        begin
            s5_cmd_reg  <= s4_cmd_reg;
            s5_mid_reg  <= s4_mid_reg;
            s5_sat_reg  <= s4_sat_reg;
            s5_prod_reg <= s5_prod_next;
        end
        if (en[5])
        begin
            s6_cmd_reg  <= s5_cmd_reg;
            s6_mid_reg  <= s5_mid_reg;
            s6_sat_reg  <= s5_sat_reg;
            s6_head_reg <= s6_head_next;
            s6_tail_reg <= s6_tail_next;
        end
        if (en[6])
        begin
            s7_cmd_reg <= s6_cmd_reg;
            rsp_reg    <= rsp_next;
        end
    end

    // A rotation result always carries a zero w.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[NST-1] && s7_cmd_reg == CMD_ROTATE) |-> (rsp.r_w == '0))
        else $error("rotation result with nonzero w");

    // The input is held off only when every stage holds an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (valid_reg == '1))
        else $error("input stalled while the pipeline has a free stage");

    // An item that is blocked in stage 4 stays there.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[3] && !en[3]) |=> valid_reg[3])
        else $error("blocked item lost from stage 4");

endmodule
